// ----- hw/rtl/clk_ka_pkg.sv -----
package clk_ka_pkg;

    localparam int TIMER_BITS     = 16;
    localparam int MAX_BEATS      = 8;
    localparam int BEAT_PERIOD    = 2;
    localparam int TMO_BITS       = 12;
    // indirect timeouts are tripled: 12 bits * 3 fits in 14
    localparam int SCALED_BITS    = TMO_BITS + 2;
    localparam int CMP_BITS       = (TIMER_BITS > SCALED_BITS) ? TIMER_BITS : SCALED_BITS;
    localparam int MAC_BITS       = 48;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = MAC_BITS;

    typedef logic [TIMER_BITS-1:0] t_timer;
    typedef logic [TMO_BITS-1:0]   t_tmo;
    typedef logic [MAC_BITS-1:0]   t_mac;

    typedef enum logic [2:0] {
        ST_INIT       = 3'd0,
        ST_WAITDISC   = 3'd1,
        ST_MONITOR    = 3'd2,
        ST_WAITRESP   = 3'd3,
        ST_TIMEOUT    = 3'd4,
        ST_DISC       = 3'd5,
        ST_RECONN     = 3'd6,
        ST_WAITRECONN = 3'd7
    } t_fsm_state;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_INIT      = 3'd1,
        CMD_BH_CONN   = 3'd2,
        CMD_BH_DISC   = 3'd3,
        CMD_DISCOVERED = 3'd4,
        CMD_DISC_FRAME = 3'd5,
        CMD_CONTACT   = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_HEARTBEAT = 2'd1,
        ACT_DISCONNECT = 2'd2,
        ACT_RECONNECT = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MONITOR_EN   = 3'd0,
        CFG_INDIRECT_EN  = 3'd1,
        CFG_MSG_TMO      = 3'd2,
        CFG_RESP_TMO     = 3'd3,
        CFG_DISC_TMO     = 3'd4,
        CFG_RECONN_TMO   = 3'd5,
        CFG_CTRL_MAC     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0] cmd;
        t_mac       src_mac;
        logic       wireless_link_present;
    } t_in_item;

    typedef struct packed {
        logic [2:0] fsm_now;
        logic [1:0] action;
        logic       is_direct;
        logic [3:0] beats_sent;
        logic       is_active;
    } t_out_item;

endpackage

// ----- hw/rtl/controller_link_keepalive_fsm.sv -----
// Controller link keepalive supervisor. Each item is one event (one-second tick, init,
// backhaul connect/disconnect, discovered, discovery frame, contact) and produces exactly
// one result item holding the state, action and flags after that event. An item is taken
// every cycle unless stalled: the state update is done in the cycle of acceptance and the
// result lands in a two-entry output buffer (result register plus skid); o_in_stall rises
// only when both entries hold results not yet taken. The user must write configuration
// registers through the plain write port only while the block is idle (unenforced).
module controller_link_keepalive_fsm (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [clk_ka_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [clk_ka_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  clk_ka_pkg::t_in_item                   i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output clk_ka_pkg::t_out_item                  o_out_data
);

    // configuration
    logic                 r_monitor_en;
    logic                 r_indirect_en;
    clk_ka_pkg::t_tmo     r_msg_tmo;
    clk_ka_pkg::t_tmo     r_resp_tmo;
    clk_ka_pkg::t_tmo     r_disc_tmo;
    clk_ka_pkg::t_tmo     r_reconn_tmo;
    clk_ka_pkg::t_mac     r_ctrl_mac;

    // supervisor state
    clk_ka_pkg::t_fsm_state r_state, n_state;
    logic                 r_active, n_active;
    logic                 r_direct, n_direct;
    clk_ka_pkg::t_timer   r_since_contact, n_since_contact;
    clk_ka_pkg::t_timer   r_since_connect, n_since_connect;
    clk_ka_pkg::t_timer   r_since_wait, n_since_wait;
    clk_ka_pkg::t_timer   r_since_beat, n_since_beat;
    clk_ka_pkg::t_timer   r_since_reconn, n_since_reconn;
    logic [3:0]           r_beat_count, n_beat_count;

    // output buffer
    logic                  r_out_valid;
    clk_ka_pkg::t_out_item r_out;
    logic                  r_skid_valid;
    clk_ka_pkg::t_out_item r_skid;

    logic                  w_in_acc;
    logic                  w_out_take;
    clk_ka_pkg::t_out_item w_res;
    clk_ka_pkg::t_action   w_action;
    logic                  w_contact_tmo;
    clk_ka_pkg::t_timer    w_inc_contact;
    clk_ka_pkg::t_timer    w_inc_connect;
    clk_ka_pkg::t_timer    w_inc_wait;
    clk_ka_pkg::t_timer    w_inc_beat;
    clk_ka_pkg::t_timer    w_inc_reconn;
    logic [clk_ka_pkg::SCALED_BITS-1:0] w_msg_scaled;
    logic [clk_ka_pkg::SCALED_BITS-1:0] w_resp_scaled;

    function automatic clk_ka_pkg::t_timer sat_inc(input clk_ka_pkg::t_timer v);
        if (v == '1) begin
            return v;
        end
        return v + clk_ka_pkg::TIMER_BITS'(1);
    endfunction

    function automatic logic [clk_ka_pkg::SCALED_BITS-1:0] scale(input clk_ka_pkg::t_tmo t,
                                                                  input logic direct);
        logic [clk_ka_pkg::SCALED_BITS-1:0] ext;
        ext = clk_ka_pkg::SCALED_BITS'(t);
        if (direct) begin
            return ext;
        end
        return ext + {ext[clk_ka_pkg::SCALED_BITS-2:0], 1'b0};
    endfunction

    function automatic logic timer_gt(input clk_ka_pkg::t_timer tmr,
                                      input logic [clk_ka_pkg::SCALED_BITS-1:0] lim);
        return clk_ka_pkg::CMP_BITS'(tmr) > clk_ka_pkg::CMP_BITS'(lim);
    endfunction

    assign w_out_take = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;
    assign w_in_acc   = i_in_valid && !r_skid_valid;

    assign w_inc_contact = sat_inc(r_since_contact);
    assign w_inc_connect = sat_inc(r_since_connect);
    assign w_inc_wait    = sat_inc(r_since_wait);
    assign w_inc_beat    = sat_inc(r_since_beat);
    assign w_inc_reconn  = sat_inc(r_since_reconn);
    assign w_msg_scaled  = scale(r_msg_tmo, r_direct);
    assign w_resp_scaled = scale(r_resp_tmo, r_direct);
    // counters advance before the check, so the check uses the incremented value
    assign w_contact_tmo = (r_direct || r_indirect_en) && timer_gt(w_inc_contact, w_msg_scaled);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_monitor_en  <= 1'b0;
            r_indirect_en <= 1'b0;
            r_msg_tmo     <= clk_ka_pkg::TMO_BITS'(30);
            r_resp_tmo    <= clk_ka_pkg::TMO_BITS'(30);
            r_disc_tmo    <= clk_ka_pkg::TMO_BITS'(30);
            r_reconn_tmo  <= clk_ka_pkg::TMO_BITS'(30);
            r_ctrl_mac    <= '0;
        end else if (i_cfg_we) begin
            case (clk_ka_pkg::t_cfg_idx'(i_cfg_idx))
                clk_ka_pkg::CFG_MONITOR_EN:  r_monitor_en  <= i_cfg_data[0];
                clk_ka_pkg::CFG_INDIRECT_EN: r_indirect_en <= i_cfg_data[0];
                clk_ka_pkg::CFG_MSG_TMO:     r_msg_tmo     <= i_cfg_data[clk_ka_pkg::TMO_BITS-1:0];
                clk_ka_pkg::CFG_RESP_TMO:    r_resp_tmo    <= i_cfg_data[clk_ka_pkg::TMO_BITS-1:0];
                clk_ka_pkg::CFG_DISC_TMO:    r_disc_tmo    <= i_cfg_data[clk_ka_pkg::TMO_BITS-1:0];
                clk_ka_pkg::CFG_RECONN_TMO:  r_reconn_tmo  <= i_cfg_data[clk_ka_pkg::TMO_BITS-1:0];
                clk_ka_pkg::CFG_CTRL_MAC:    r_ctrl_mac    <= i_cfg_data[clk_ka_pkg::MAC_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // next state and action for the accepted item
    always_comb begin
        n_state         = r_state;
        n_active        = r_active;
        n_direct        = r_direct;
        n_since_contact = r_since_contact;
        n_since_connect = r_since_connect;
        n_since_wait    = r_since_wait;
        n_since_beat    = r_since_beat;
        n_since_reconn  = r_since_reconn;
        n_beat_count    = r_beat_count;
        w_action        = clk_ka_pkg::ACT_NONE;

        case (clk_ka_pkg::t_cmd'(i_in_data.cmd))
            clk_ka_pkg::CMD_TICK: begin
                n_since_contact = w_inc_contact;
                n_since_connect = w_inc_connect;
                n_since_wait    = w_inc_wait;
                n_since_beat    = w_inc_beat;
                n_since_reconn  = w_inc_reconn;
                if (r_active) begin
                    case (r_state)
                        clk_ka_pkg::ST_WAITDISC: begin
                            if (timer_gt(w_inc_connect, clk_ka_pkg::SCALED_BITS'(r_disc_tmo))) begin
                                n_state = clk_ka_pkg::ST_TIMEOUT;
                            end
                        end
                        clk_ka_pkg::ST_MONITOR: begin
                            if (w_contact_tmo) begin
                                n_beat_count = '0;
                                n_since_beat = '0;
                                n_since_wait = '0;
                                n_state      = clk_ka_pkg::ST_WAITRESP;
                            end
                        end
                        clk_ka_pkg::ST_WAITRESP: begin
                            if (!w_contact_tmo) begin
                                n_state = clk_ka_pkg::ST_MONITOR;
                            end else if (timer_gt(w_inc_wait, w_resp_scaled)) begin
                                n_state = clk_ka_pkg::ST_TIMEOUT;
                            end else if (r_beat_count < 4'(clk_ka_pkg::MAX_BEATS) &&
                                         timer_gt(w_inc_beat,
                                                  clk_ka_pkg::SCALED_BITS'(clk_ka_pkg::BEAT_PERIOD))) begin
                                w_action     = clk_ka_pkg::ACT_HEARTBEAT;
                                n_beat_count = r_beat_count + 4'd1;
                                n_since_beat = '0;
                            end
                        end
                        clk_ka_pkg::ST_TIMEOUT: begin
                            if (i_in_data.wireless_link_present) begin
                                n_state = clk_ka_pkg::ST_RECONN;
                            end else begin
                                w_action = clk_ka_pkg::ACT_DISCONNECT;
                            end
                        end
                        clk_ka_pkg::ST_RECONN: begin
                            w_action       = clk_ka_pkg::ACT_RECONNECT;
                            n_since_reconn = '0;
                            n_state        = clk_ka_pkg::ST_WAITRECONN;
                        end
                        clk_ka_pkg::ST_WAITRECONN: begin
                            if (timer_gt(w_inc_reconn, clk_ka_pkg::SCALED_BITS'(r_reconn_tmo))) begin
                                n_state = clk_ka_pkg::ST_RECONN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            clk_ka_pkg::CMD_INIT: begin
                n_active = r_monitor_en;
            end
            clk_ka_pkg::CMD_BH_CONN: begin
                n_direct        = 1'b0;
                n_since_connect = '0;
                n_state         = clk_ka_pkg::ST_WAITDISC;
            end
            clk_ka_pkg::CMD_BH_DISC: begin
                n_state = clk_ka_pkg::ST_DISC;
            end
            clk_ka_pkg::CMD_DISCOVERED: begin
                n_state = clk_ka_pkg::ST_MONITOR;
            end
            clk_ka_pkg::CMD_DISC_FRAME: begin
                if (r_state == clk_ka_pkg::ST_MONITOR && i_in_data.src_mac == r_ctrl_mac) begin
                    n_direct = 1'b1;
                end
            end
            clk_ka_pkg::CMD_CONTACT: begin
                n_since_contact = '0;
            end
            default: begin
            end
        endcase

        w_res.fsm_now    = n_state;
        w_res.action     = w_action;
        w_res.is_direct  = n_direct;
        w_res.beats_sent = n_beat_count;
        w_res.is_active  = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= clk_ka_pkg::ST_INIT;
            r_active        <= 1'b0;
            r_direct        <= 1'b0;
            r_since_contact <= '0;
            r_since_connect <= '0;
            r_since_wait    <= '0;
            r_since_beat    <= '0;
            r_since_reconn  <= '0;
            r_beat_count    <= '0;
        end else if (w_in_acc) begin
            r_state         <= n_state;
            r_active        <= n_active;
            r_direct        <= n_direct;
            r_since_contact <= n_since_contact;
            r_since_connect <= n_since_connect;
            r_since_wait    <= n_since_wait;
            r_since_beat    <= n_since_beat;
            r_since_reconn  <= n_since_reconn;
            r_beat_count    <= n_beat_count;
        end
    end

    // result register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_in_acc;
                end
            end else if (w_in_acc) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_in_acc && !r_out_valid) begin
            r_out <= w_res;
        end
        if (w_in_acc && r_out_valid && !w_out_take) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds an item while the result register is empty");

    a_beats_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat_count <= 4'(clk_ka_pkg::MAX_BEATS))
        else $error("heartbeat count beyond its limit");

    a_action_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && clk_ka_pkg::t_cmd'(i_in_data.cmd) != clk_ka_pkg::CMD_TICK)
        |-> w_res.action == clk_ka_pkg::ACT_NONE)
        else $error("action raised on an event other than a tick");

    a_beat_in_waitresp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_res.action == clk_ka_pkg::ACT_HEARTBEAT)
        |=> r_state == clk_ka_pkg::ST_WAITRESP)
        else $error("heartbeat sent outside the response wait");

    a_stalled_take_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("accepted item lost while the result register was held");

endmodule

// ----- verif/tb_controller_link_keepalive_fsm.sv -----
`timescale 1ns / 1ps

module tb_controller_link_keepalive_fsm;

    localparam int          LIMIT_CYCLES   = 1_000_000;
    localparam int unsigned INDIRECT_SCALE = 3;
    localparam logic [2:0]  CMD_SPARE      = 3'd7;   // unused code, block must ignore it

    // Mirror of the supervisor: predicts one report per accepted event item.
    class keepalive_scoreboard;
        clk_ka_pkg::t_fsm_state  st;
        bit                      active, direct;
        clk_ka_pkg::t_timer      sec_contact, sec_connect, sec_wait, sec_beat, sec_reconn;
        logic [3:0]              beats;
        bit                      mon_en, ind_en;
        clk_ka_pkg::t_tmo        msg_tmo, resp_tmo, disc_tmo, reconn_tmo;
        clk_ka_pkg::t_mac        ctrl_mac;
        clk_ka_pkg::t_out_item   reports_due[$];
        int                      errors, checked, n_beats, n_disc_req, n_reconn_req;

        function new();
            st = clk_ka_pkg::ST_INIT;
            active = 0;
            direct = 0;
            sec_contact = '0;
            sec_connect = '0;
            sec_wait = '0;
            sec_beat = '0;
            sec_reconn = '0;
            beats = '0;
            mon_en = 0;
            ind_en = 0;
            msg_tmo = 30;
            resp_tmo = 30;
            disc_tmo = 30;
            reconn_tmo = 30;
            ctrl_mac = '0;
        endfunction

        function void set_reg(clk_ka_pkg::t_cfg_idx idx,
                              logic [clk_ka_pkg::CFG_DATA_BITS-1:0] d);
            case (idx)
                clk_ka_pkg::CFG_MONITOR_EN:  mon_en = d[0];
                clk_ka_pkg::CFG_INDIRECT_EN: ind_en = d[0];
                clk_ka_pkg::CFG_MSG_TMO:     msg_tmo = d[clk_ka_pkg::TMO_BITS-1:0];
                clk_ka_pkg::CFG_RESP_TMO:    resp_tmo = d[clk_ka_pkg::TMO_BITS-1:0];
                clk_ka_pkg::CFG_DISC_TMO:    disc_tmo = d[clk_ka_pkg::TMO_BITS-1:0];
                clk_ka_pkg::CFG_RECONN_TMO:  reconn_tmo = d[clk_ka_pkg::TMO_BITS-1:0];
                clk_ka_pkg::CFG_CTRL_MAC:    ctrl_mac = d[clk_ka_pkg::MAC_BITS-1:0];
                default: ;
            endcase
        endfunction

        function clk_ka_pkg::t_timer bump(clk_ka_pkg::t_timer v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function int unsigned scaled(clk_ka_pkg::t_tmo t);
            return direct ? int'(t) : int'(t) * INDIRECT_SCALE;
        endfunction

        function bit contact_lapsed();
            if (!direct && !ind_en)
                return 0;
            return sec_contact > scaled(msg_tmo);
        endfunction

        function clk_ka_pkg::t_action on_tick(bit wireless);
            clk_ka_pkg::t_action act;
            act = clk_ka_pkg::ACT_NONE;
            sec_contact = bump(sec_contact);
            sec_connect = bump(sec_connect);
            sec_wait = bump(sec_wait);
            sec_beat = bump(sec_beat);
            sec_reconn = bump(sec_reconn);
            if (!active)
                return clk_ka_pkg::ACT_NONE;
            case (st)
                clk_ka_pkg::ST_WAITDISC: begin
                    if (sec_connect > disc_tmo)
                        st = clk_ka_pkg::ST_TIMEOUT;
                end
                clk_ka_pkg::ST_MONITOR: begin
                    if (contact_lapsed()) begin
                        beats = '0;
                        sec_beat = '0;
                        sec_wait = '0;
                        st = clk_ka_pkg::ST_WAITRESP;
                    end
                end
                clk_ka_pkg::ST_WAITRESP: begin
                    if (!contact_lapsed()) begin
                        st = clk_ka_pkg::ST_MONITOR;
                    end else if (sec_wait > scaled(resp_tmo)) begin
                        st = clk_ka_pkg::ST_TIMEOUT;
                    end else if (beats < clk_ka_pkg::MAX_BEATS &&
                                 sec_beat > clk_ka_pkg::BEAT_PERIOD) begin
                        act = clk_ka_pkg::ACT_HEARTBEAT;
                        beats = beats + 1'b1;
                        sec_beat = '0;
                    end
                end
                clk_ka_pkg::ST_TIMEOUT: begin
                    if (wireless)
                        st = clk_ka_pkg::ST_RECONN;
                    else
                        act = clk_ka_pkg::ACT_DISCONNECT;
                end
                clk_ka_pkg::ST_RECONN: begin
                    act = clk_ka_pkg::ACT_RECONNECT;
                    sec_reconn = '0;
                    st = clk_ka_pkg::ST_WAITRECONN;
                end
                clk_ka_pkg::ST_WAITRECONN: begin
                    if (sec_reconn > reconn_tmo)
                        st = clk_ka_pkg::ST_RECONN;
                end
                default: ;
            endcase
            return act;
        endfunction

        function void note_event(clk_ka_pkg::t_in_item it);
            clk_ka_pkg::t_action   act;
            clk_ka_pkg::t_out_item rep;
            act = clk_ka_pkg::ACT_NONE;
            case (it.cmd)
                clk_ka_pkg::CMD_TICK:       act = on_tick(it.wireless_link_present);
                clk_ka_pkg::CMD_INIT:       active = mon_en;
                clk_ka_pkg::CMD_BH_CONN: begin
                    direct = 0;
                    sec_connect = '0;
                    st = clk_ka_pkg::ST_WAITDISC;
                end
                clk_ka_pkg::CMD_BH_DISC:    st = clk_ka_pkg::ST_DISC;
                clk_ka_pkg::CMD_DISCOVERED: st = clk_ka_pkg::ST_MONITOR;
                clk_ka_pkg::CMD_DISC_FRAME: begin
                    if (st == clk_ka_pkg::ST_MONITOR && it.src_mac == ctrl_mac)
                        direct = 1;
                end
                clk_ka_pkg::CMD_CONTACT:    sec_contact = '0;
                default: ;
            endcase
            case (act)
                clk_ka_pkg::ACT_HEARTBEAT:  n_beats++;
                clk_ka_pkg::ACT_DISCONNECT: n_disc_req++;
                clk_ka_pkg::ACT_RECONNECT:  n_reconn_req++;
                default: ;
            endcase
            rep.fsm_now = st;
            rep.action = act;
            rep.is_direct = direct;
            rep.beats_sent = beats;
            rep.is_active = active;
            reports_due.push_back(rep);
        endfunction

        function void check_report(clk_ka_pkg::t_out_item got);
            clk_ka_pkg::t_out_item want;
            if (reports_due.size() == 0) begin
                $error("result item with nothing expected: %h", got);
                errors++;
                return;
            end
            want = reports_due.pop_front();
            checked++;
            if (got.fsm_now !== want.fsm_now) begin
                $error("fsm_now: expected %0d, got %0d", want.fsm_now, got.fsm_now);
                errors++;
            end
            if (got.action !== want.action) begin
                $error("action: expected %0d, got %0d", want.action, got.action);
                errors++;
            end
            if (got.is_direct !== want.is_direct) begin
                $error("is_direct: expected %0d, got %0d", want.is_direct, got.is_direct);
                errors++;
            end
            if (got.beats_sent !== want.beats_sent) begin
                $error("beats_sent: expected %0d, got %0d", want.beats_sent, got.beats_sent);
                errors++;
            end
            if (got.is_active !== want.is_active) begin
                $error("is_active: expected %0d, got %0d", want.is_active, got.is_active);
                errors++;
            end
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_we = 1'b0;
    logic [clk_ka_pkg::CFG_IDX_BITS-1:0]   cfg_idx = '0;
    logic [clk_ka_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                                  in_valid = 1'b0;
    clk_ka_pkg::t_in_item                  in_data = '0;
    logic                                  out_stall = 1'b0;
    logic                                  in_stall;
    logic                                  out_valid;
    clk_ka_pkg::t_out_item                 out_data;

    keepalive_scoreboard sb = new();
    bit               quiet = 1'b0;     // no gaps and no stalls while set
    clk_ka_pkg::t_mac cur_mac = '0;
    int               events_sent = 0;
    int               cycles = 0;

    controller_link_keepalive_fsm DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // input side first, so a same-edge report always finds its expectation
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            sb.note_event(in_data);
        if (rst_n && out_valid && !out_stall)
            sb.check_report(out_data);
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic clk_ka_pkg::t_mac rand_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[clk_ka_pkg::MAC_BITS-1:0];
    endfunction

    initial begin
        @(posedge clk);
        forever begin
            if (quiet) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_stall <= 1'b1;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    task automatic put_reg(clk_ka_pkg::t_cfg_idx idx,
                           logic [clk_ka_pkg::CFG_DATA_BITS-1:0] d);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        sb.set_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic program_regs(bit men, bit ien, int msg, int resp, int disc, int recon,
                                clk_ka_pkg::t_mac mac);
        put_reg(clk_ka_pkg::CFG_MONITOR_EN, clk_ka_pkg::CFG_DATA_BITS'(men));
        put_reg(clk_ka_pkg::CFG_INDIRECT_EN, clk_ka_pkg::CFG_DATA_BITS'(ien));
        put_reg(clk_ka_pkg::CFG_MSG_TMO, clk_ka_pkg::CFG_DATA_BITS'(msg));
        put_reg(clk_ka_pkg::CFG_RESP_TMO, clk_ka_pkg::CFG_DATA_BITS'(resp));
        put_reg(clk_ka_pkg::CFG_DISC_TMO, clk_ka_pkg::CFG_DATA_BITS'(disc));
        put_reg(clk_ka_pkg::CFG_RECONN_TMO, clk_ka_pkg::CFG_DATA_BITS'(recon));
        put_reg(clk_ka_pkg::CFG_CTRL_MAC, mac);
        cfg_we <= 1'b0;
        cur_mac = mac;
    endtask

    task automatic send_event(logic [2:0] c, clk_ka_pkg::t_mac mac, bit wl);
        clk_ka_pkg::t_in_item it;
        int                   gap;
        it.cmd = c;
        it.src_mac = mac;
        it.wireless_link_present = wl;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        events_sent++;
    endtask

    task automatic send_tick(bit wl);
        send_event(clk_ka_pkg::CMD_TICK, rand_mac(), wl);
    endtask

    // wait for every report, then pad with idle clocks so the block is idle for a register write
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic send_random_event();
        int               r;
        logic [2:0]       c;
        clk_ka_pkg::t_mac m;
        r = $urandom_range(0, 99);
        if (r < 60)      c = clk_ka_pkg::CMD_TICK;
        else if (r < 68) c = clk_ka_pkg::CMD_CONTACT;
        else if (r < 76) c = clk_ka_pkg::CMD_DISC_FRAME;
        else if (r < 82) c = clk_ka_pkg::CMD_DISCOVERED;
        else if (r < 87) c = clk_ka_pkg::CMD_BH_CONN;
        else if (r < 91) c = clk_ka_pkg::CMD_BH_DISC;
        else if (r < 96) c = clk_ka_pkg::CMD_INIT;
        else if (r < 98) c = CMD_SPARE;
        else             c = 3'($urandom_range(0, 7));
        m = $urandom_range(0, 1) ? cur_mac : rand_mac();
        send_event(c, m, $urandom_range(0, 1));
    endtask

    // bring-up as the link sees it, then free-running events
    task automatic run_session();
        send_event(clk_ka_pkg::CMD_INIT, rand_mac(), $urandom_range(0, 1));
        send_event(clk_ka_pkg::CMD_BH_CONN, rand_mac(), $urandom_range(0, 1));
        repeat ($urandom_range(0, 3)) send_tick($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) begin
            send_event(clk_ka_pkg::CMD_DISCOVERED, rand_mac(), $urandom_range(0, 1));
            if ($urandom_range(0, 1))
                send_event(clk_ka_pkg::CMD_DISC_FRAME, cur_mac, $urandom_range(0, 1));
            send_event(clk_ka_pkg::CMD_CONTACT, rand_mac(), $urandom_range(0, 1));
        end
        if ($urandom_range(0, 9) < 3)
            repeat ($urandom_range(10, 40)) send_tick($urandom_range(0, 3) == 0);
        repeat ($urandom_range(8, 20)) send_random_event();
    endtask

    function automatic int pick_tmo();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        if (r < 92)
            return $urandom_range(7, 40);
        return $urandom_range(3400, 3600);
    endfunction

    initial begin
        int start;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through every state
        program_regs(1, 0, 1, 9, 1, 1, '1);
        send_event(CMD_SPARE, '0, 0);
        send_tick(0);                        // inactive: counters only
        send_event(clk_ka_pkg::CMD_INIT, '0, 0);
        send_event(clk_ka_pkg::CMD_BH_CONN, '0, 0);
        send_tick(0);
        send_tick(0);                        // discovery window missed
        send_tick(0);                        // no wireless link: disconnect request
        send_tick(0);                        // ... and again
        send_tick(1);
        send_tick(0);                        // reconnect request
        send_tick(0);
        send_tick(0);
        send_event(clk_ka_pkg::CMD_DISC_FRAME, '1, 1);   // outside monitor, ignored
        send_event(clk_ka_pkg::CMD_DISCOVERED, '0, 0);
        send_event(clk_ka_pkg::CMD_DISC_FRAME, '0, 0);   // wrong source
        send_event(clk_ka_pkg::CMD_DISC_FRAME, '1, 0);   // direct link now
        send_event(clk_ka_pkg::CMD_CONTACT, '1, 1);
        repeat (12) send_tick(0);            // heartbeats, then response timeout
        send_event(clk_ka_pkg::CMD_BH_DISC, '1, 1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: program_regs(1, 1, 0, 0, 0, 0, '0);
                1: program_regs(1, 0, 3600, 3600, 3600, 3600, '1);
                2: program_regs(0, $urandom_range(0, 1), pick_tmo(), pick_tmo(),
                                pick_tmo(), pick_tmo(), rand_mac());
                3: program_regs(1, 1, 2, 12, 5, 3, rand_mac());  // reaches the beat cap
                default: program_regs(1, $urandom_range(0, 1), pick_tmo(), pick_tmo(),
                                      pick_tmo(), pick_tmo(), rand_mac());
            endcase
            quiet = (ph == 4) || ($urandom_range(0, 4) == 0);
            start = events_sent;
            while (events_sent - start < 40)
                run_session();
            drain();
        end

        $display("Ran %0d event items through a directed walk and eight random phases;",
                 events_sent);
        $display("%0d reports checked: %0d heartbeats, %0d disconnect, %0d reconnect requests",
                 sb.checked, sb.n_beats, sb.n_disc_req, sb.n_reconn_req);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- controller_link_keepalive_fsm.f -----
hw/rtl/clk_ka_pkg.sv
hw/rtl/controller_link_keepalive_fsm.sv
verif/tb_controller_link_keepalive_fsm.sv
